### rtl/core/mf3s_pkg.sv
package mf3s_pkg;

    localparam int PIX_W     = 8;
    localparam int FW_W      = 11;
    localparam int FH_W      = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int WIN_N     = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 12'd480;

    typedef logic [PIX_W-1:0] t_pixel;
    // row-major, oldest row first, leftmost column first
    typedef logic [WIN_N-1:0][PIX_W-1:0] t_window;

    // fixed 19 compare-exchange median network, fifth smallest of nine
    function automatic t_pixel median9(input t_window win);
        t_window v;
        t_pixel  t;
        v = win;
        if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
        if (v[4] > v[5]) begin t = v[4]; v[4] = v[5]; v[5] = t; end
        if (v[7] > v[8]) begin t = v[7]; v[7] = v[8]; v[8] = t; end
        if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
        if (v[3] > v[4]) begin t = v[3]; v[3] = v[4]; v[4] = t; end
        if (v[6] > v[7]) begin t = v[6]; v[6] = v[7]; v[7] = t; end
        if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
        if (v[4] > v[5]) begin t = v[4]; v[4] = v[5]; v[5] = t; end
        if (v[7] > v[8]) begin t = v[7]; v[7] = v[8]; v[8] = t; end
        if (v[0] > v[3]) begin t = v[0]; v[0] = v[3]; v[3] = t; end
        if (v[5] > v[8]) begin t = v[5]; v[5] = v[8]; v[8] = t; end
        if (v[4] > v[7]) begin t = v[4]; v[4] = v[7]; v[7] = t; end
        if (v[3] > v[6]) begin t = v[3]; v[3] = v[6]; v[6] = t; end
        if (v[1] > v[4]) begin t = v[1]; v[1] = v[4]; v[4] = t; end
        if (v[2] > v[5]) begin t = v[2]; v[2] = v[5]; v[5] = t; end
        if (v[4] > v[7]) begin t = v[4]; v[4] = v[7]; v[7] = t; end
        if (v[4] > v[2]) begin t = v[4]; v[4] = v[2]; v[2] = t; end
        if (v[6] > v[4]) begin t = v[6]; v[6] = v[4]; v[4] = t; end
        if (v[4] > v[2]) begin t = v[4]; v[4] = v[2]; v[2] = t; end
        return v[4];
    endfunction

endpackage

### rtl/core/mf3s_ram.sv
module mf3s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/median_filter_3x3_stream.sv
// Streaming 3x3 median filter for 8-bit grey pixels in raster order. One pixel
// is accepted every clock while the output side keeps up; a result (the median
// of the window centered one row up and one column left) passes in turn through
// the registered read of the two line-store RAMs, the window register and the
// result register after its pixel is accepted.
// Pixels in the first two rows or first two columns give no result, and tlast
// marks the last interior pixel of the frame. Writing frame_width (clamped to
// 3..MAX_WIDTH) or frame_height (at least 3) restarts the frame at the next
// pixel; write them only while the block is drained. The line stores need no
// clearing after reset.
module median_filter_3x3_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mf3s_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mf3s_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  mf3s_pkg::t_pixel                    i_s_tdata,   // [7:0] pixel
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output mf3s_pkg::t_pixel                    o_m_tdata,   // [7:0] median
    output logic                                o_m_tlast
);

    import mf3s_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic [EW-1:0]   w_fw_ext;
    logic [EW-1:0]   w_eff_w;
    logic [CW-1:0]   w_col_last;
    logic [FH_W-1:0] w_row_last;

    logic [CW-1:0]   r_col, n_col;
    logic [FH_W-1:0] r_row, n_row;

    logic            w_acc, w_adv1, w_adv2, w_cfg_hit;

    logic            r_v1, r_emit1, r_last1;
    t_pixel          r_px1;
    logic [CW-1:0]   r_col1;
    t_pixel          w_top, w_mid;

    t_window         r_win, n_win;
    logic            r_v2, r_emit2, r_last2;

    logic            r_ov, r_olast;
    t_pixel          r_med;

    // effective frame geometry
    assign w_fw_ext = EW'(r_frame_width);
    always_comb begin
        if (w_fw_ext < EW'(3)) begin
            w_eff_w = EW'(3);
        end else if (w_fw_ext > EW'(MAX_WIDTH)) begin
            w_eff_w = EW'(MAX_WIDTH);
        end else begin
            w_eff_w = w_fw_ext;
        end
    end
    assign w_col_last = CW'(w_eff_w - EW'(1));
    assign w_row_last = (r_frame_height < FH_W'(3)) ? FH_W'(2) : r_frame_height - 1'b1;

    // handshake chain
    assign w_adv2     = r_v2 && (!r_emit2 || !r_ov || i_m_tready);
    assign w_adv1     = r_v1 && (!r_v2 || w_adv2);
    assign o_s_tready = !r_v1 || w_adv1;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_cfg_hit  = i_cfg_we;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_acc) begin
            if (r_col == w_col_last) begin
                n_col = '0;
                n_row = (r_row == w_row_last) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
            r_col          <= '0;
            r_row          <= '0;
        end else if (w_cfg_hit) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[FH_W-1:0];
            endcase
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1: line-store read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_acc) begin
            r_v1 <= 1'b1;
        end else if (w_adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_px1   <= i_s_tdata;
            r_col1  <= r_col;
            r_emit1 <= (r_row >= FH_W'(2)) && (r_col >= CW'(2));
            r_last1 <= (r_row == w_row_last) && (r_col == w_col_last);
        end
    end

    // near holds the previous row, far the row before it
    mf3s_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_near (
        .i_clk   (i_clk),
        .i_we    (w_adv1),
        .i_waddr (r_col1),
        .i_wdata (r_px1),
        .i_re    (w_acc),
        .i_raddr (r_col),
        .o_rdata (w_mid)
    );

    mf3s_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_far (
        .i_clk   (i_clk),
        .i_we    (w_adv1),
        .i_waddr (r_col1),
        .i_wdata (w_mid),
        .i_re    (w_acc),
        .i_raddr (r_col),
        .o_rdata (w_top)
    );

    // stage 2: window shifts left and takes the new column
    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = w_top;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = w_mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_px1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_win <= '0;
        end else begin
            if (w_adv1) begin
                r_win <= n_win;
                r_v2  <= 1'b1;
            end else if (w_adv2) begin
                r_v2  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_emit2 <= r_emit1;
            r_last2 <= r_last1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv2 && r_emit2) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_emit2) begin
            r_med   <= median9(r_win);
            r_olast <= r_last2;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_med;
    assign o_m_tlast  = r_olast;

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= w_col_last)
        else $error("column position beyond row end");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= w_row_last)
        else $error("row position beyond frame end");

    a_no_raw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_v1) |-> (r_col1 != r_col))
        else $error("line-store read hits the column still being written");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_last2) |-> r_emit2)
        else $error("end-of-frame flag on a border pixel");

endmodule
